>>> hw/rtl/scclk_pkg.sv
// ----------------------------------------------------------------------------
// Sector cache clock replacement package
// Sizes, operation codes, sequencer states and the result push record.
// ----------------------------------------------------------------------------
package scclk_pkg;

   localparam int ENTRIES      = 64;
   localparam int SECTOR_BYTES = 512;
   localparam int SECTOR_BITS  = 32;

   localparam int IDX_W     = $clog2(ENTRIES);
   localparam int TAG_W     = SECTOR_BITS;
   localparam int SEC_SHIFT = $clog2(SECTOR_BYTES);

   localparam int OP_W     = 2;
   localparam int SECTOR_W = 32;
   localparam int OFFSET_W = 9;
   localparam int LENGTH_W = 10;
   localparam int ENTRY_W  = 6;
   localparam int ADDR_W   = 15;

   localparam logic [OP_W-1:0] OP_READ  = 2'd0;
   localparam logic [OP_W-1:0] OP_WRITE = 2'd1;
   localparam logic [OP_W-1:0] OP_FLUSH = 2'd2;
   localparam logic [OP_W-1:0] OP_NONE  = 2'd3;

   typedef enum logic [2:0] {
      S_IDLE,
      S_LOOK,
      S_FLUSH,
      S_SWEEP,
      S_VICTIM,
      S_FILL,
      S_EMIT
   } state_type;

   typedef struct packed {
      logic                valid;
      logic                hit;
      logic [ENTRY_W-1:0]  entry;
      logic                fill;
      logic                wb;
      logic [SECTOR_W-1:0] wb_sector;
      logic [ADDR_W-1:0]   addr;
      logic [LENGTH_W-1:0] len;
      logic                last;
   } push_type;

endpackage

>>> hw/rtl/scclk_if.sv
// ----------------------------------------------------------------------------
// Sector cache clock replacement channels
// Request and response valid/ready channels with their payload.
// ----------------------------------------------------------------------------
interface scclk_req_if;
   logic                          valid;
   logic                          ready;
   logic [scclk_pkg::OP_W-1:0]     operation;
   logic [scclk_pkg::SECTOR_W-1:0] sector;
   logic [scclk_pkg::OFFSET_W-1:0] offset;
   logic [scclk_pkg::LENGTH_W-1:0] length;

   modport source (output valid, operation, sector, offset, length, input ready);
   modport sink   (input valid, operation, sector, offset, length, output ready);
endinterface

interface scclk_rsp_if;
   logic                          valid;
   logic                          ready;
   logic                          hit;
   logic [scclk_pkg::ENTRY_W-1:0]  entry;
   logic                          fill_needed;
   logic                          writeback_needed;
   logic [scclk_pkg::SECTOR_W-1:0] writeback_sector;
   logic [scclk_pkg::ADDR_W-1:0]   data_address;
   logic [scclk_pkg::LENGTH_W-1:0] copy_length;
   logic                          last;

   modport source (output valid, hit, entry, fill_needed, writeback_needed,
                   writeback_sector, data_address, copy_length, last,
                   input ready);
   modport sink   (input valid, hit, entry, fill_needed, writeback_needed,
                   writeback_sector, data_address, copy_length, last,
                   output ready);
endinterface

>>> hw/rtl/scclk_tag_ram.sv
// ----------------------------------------------------------------------------
// Sector cache tag memory
// One write port, one read port with registered read data.
// ----------------------------------------------------------------------------
module scclk_tag_ram (
   input  logic                        clock,
   input  logic                        wr_en,
   input  logic [scclk_pkg::IDX_W-1:0] wr_addr,
   input  logic [scclk_pkg::TAG_W-1:0] wr_data,
   input  logic                        rd_en,
   input  logic [scclk_pkg::IDX_W-1:0] rd_addr,
   output logic [scclk_pkg::TAG_W-1:0] rd_data
);

   logic [scclk_pkg::TAG_W-1:0] mem [scclk_pkg::ENTRIES];
   logic [scclk_pkg::TAG_W-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      if (rd_en) begin
         rd_data_ff <= mem[rd_addr];
      end
   end

   assign rd_data = rd_data_ff;

endmodule

>>> hw/rtl/scclk_engine.sv
// ----------------------------------------------------------------------------
// Sector cache lookup and replacement sequencer
// Scans tags through one compare stage, runs the clock sweep and the flush
// scan, keeps the entry status bits and the hand, and pushes result items.
// ----------------------------------------------------------------------------
module scclk_engine (
   input  logic                 clock,
   input  logic                 reset,
   scclk_req_if.sink            req,
   input  logic                 out_free,
   output scclk_pkg::push_type  push
);

   localparam logic [scclk_pkg::IDX_W-1:0] LAST_IDX = scclk_pkg::IDX_W'(scclk_pkg::ENTRIES - 1);

   scclk_pkg::state_type state_ff, state_in;

   logic [scclk_pkg::OP_W-1:0]     op_ff, op_in;
   logic [scclk_pkg::TAG_W-1:0]    sec_ff, sec_in;
   logic [scclk_pkg::OFFSET_W-1:0] off_ff, off_in;
   logic [scclk_pkg::LENGTH_W-1:0] len_ff, len_in;

   logic [scclk_pkg::IDX_W-1:0] rd_idx_ff, rd_idx_in;
   logic                        rd_done_ff, rd_done_in;
   logic                        cmp_vld_ff, cmp_vld_in;
   logic [scclk_pkg::IDX_W-1:0] cmp_idx_ff, cmp_idx_in;

   logic [scclk_pkg::ENTRIES-1:0] valid_ff, valid_in;
   logic [scclk_pkg::ENTRIES-1:0] dirty_ff, dirty_in;
   logic [scclk_pkg::ENTRIES-1:0] ref_ff, ref_in;
   logic [scclk_pkg::IDX_W-1:0]   hand_ff, hand_in;
   logic [scclk_pkg::IDX_W-1:0]   victim_ff, victim_in;

   logic                           pend_vld_ff, pend_vld_in;
   logic                           pend_hit_ff, pend_hit_in;
   logic [scclk_pkg::IDX_W-1:0]    pend_entry_ff, pend_entry_in;
   logic                           pend_fill_ff, pend_fill_in;
   logic                           pend_wb_ff, pend_wb_in;
   logic [scclk_pkg::TAG_W-1:0]    pend_wbsec_ff, pend_wbsec_in;
   logic [scclk_pkg::OFFSET_W-1:0] pend_off_ff, pend_off_in;
   logic [scclk_pkg::LENGTH_W-1:0] pend_len_ff, pend_len_in;

   logic                        accept;
   logic                        scanning;
   logic                        hit_now;
   logic                        dirty_now;
   logic                        last_cmp;
   logic                        stall;
   logic                        rd_en;
   logic [scclk_pkg::IDX_W-1:0] rd_addr;
   logic                        wr_en;
   logic [scclk_pkg::TAG_W-1:0] tag_q;
   logic                        do_push;
   logic [scclk_pkg::IDX_W-1:0] hand_next;

   scclk_tag_ram u_tag_ram (
      .clock   (clock),
      .wr_en   (wr_en),
      .wr_addr (victim_ff),
      .wr_data (sec_ff),
      .rd_en   (rd_en),
      .rd_addr (rd_addr),
      .rd_data (tag_q)
   );

   assign accept    = req.valid && req.ready;
   assign hand_next = (hand_ff == LAST_IDX) ? '0 : hand_ff + 1'b1;
   assign hit_now   = cmp_vld_ff && valid_ff[cmp_idx_ff] && (tag_q == sec_ff);
   assign dirty_now = cmp_vld_ff && valid_ff[cmp_idx_ff] && dirty_ff[cmp_idx_ff];
   assign last_cmp  = cmp_vld_ff && (cmp_idx_ff == LAST_IDX);

   // next state
   always_comb begin
      state_in = state_ff;
      case (state_ff)
         scclk_pkg::S_IDLE: begin
            if (accept) begin
               case (req.operation)
                  scclk_pkg::OP_READ, scclk_pkg::OP_WRITE: state_in = scclk_pkg::S_LOOK;
                  scclk_pkg::OP_FLUSH: state_in = scclk_pkg::S_FLUSH;
                  default: state_in = scclk_pkg::S_IDLE;
               endcase
            end
         end
         scclk_pkg::S_LOOK: begin
            if (hit_now) begin
               state_in = scclk_pkg::S_EMIT;
            end else if (last_cmp) begin
               state_in = scclk_pkg::S_SWEEP;
            end
         end
         scclk_pkg::S_FLUSH: begin
            if (last_cmp && !stall) begin
               state_in = (pend_vld_ff || dirty_now) ? scclk_pkg::S_EMIT : scclk_pkg::S_IDLE;
            end
         end
         scclk_pkg::S_SWEEP: begin
            if (!(valid_ff[hand_ff] && ref_ff[hand_ff])) begin
               state_in = scclk_pkg::S_VICTIM;
            end
         end
         scclk_pkg::S_VICTIM: state_in = scclk_pkg::S_FILL;
         scclk_pkg::S_FILL:   state_in = scclk_pkg::S_EMIT;
         scclk_pkg::S_EMIT: begin
            if (out_free) begin
               state_in = scclk_pkg::S_IDLE;
            end
         end
         default: state_in = scclk_pkg::S_IDLE;
      endcase
   end

   // control outputs
   always_comb begin
      scanning  = (state_ff == scclk_pkg::S_LOOK) || (state_ff == scclk_pkg::S_FLUSH);
      stall     = (state_ff == scclk_pkg::S_FLUSH) && dirty_now && pend_vld_ff && !out_free;
      req.ready = (state_ff == scclk_pkg::S_IDLE);
      wr_en     = (state_ff == scclk_pkg::S_FILL);
      rd_en     = 1'b0;
      rd_addr   = rd_idx_ff;
      do_push   = 1'b0;
      case (state_ff)
         scclk_pkg::S_LOOK: rd_en = !rd_done_ff;
         scclk_pkg::S_FLUSH: begin
            rd_en   = !rd_done_ff && !stall;
            do_push = dirty_now && pend_vld_ff && out_free;
         end
         scclk_pkg::S_VICTIM: begin
            rd_en   = 1'b1;
            rd_addr = victim_ff;
         end
         scclk_pkg::S_EMIT: do_push = out_free;
         default: rd_en = 1'b0;
      endcase
   end

   // datapath next values
   always_comb begin
      op_in         = op_ff;
      sec_in        = sec_ff;
      off_in        = off_ff;
      len_in        = len_ff;
      rd_idx_in     = rd_idx_ff;
      rd_done_in    = rd_done_ff;
      cmp_vld_in    = cmp_vld_ff;
      cmp_idx_in    = cmp_idx_ff;
      valid_in      = valid_ff;
      dirty_in      = dirty_ff;
      ref_in        = ref_ff;
      hand_in       = hand_ff;
      victim_in     = victim_ff;
      pend_vld_in   = pend_vld_ff;
      pend_hit_in   = pend_hit_ff;
      pend_entry_in = pend_entry_ff;
      pend_fill_in  = pend_fill_ff;
      pend_wb_in    = pend_wb_ff;
      pend_wbsec_in = pend_wbsec_ff;
      pend_off_in   = pend_off_ff;
      pend_len_in   = pend_len_ff;

      if (accept) begin
         op_in       = req.operation;
         sec_in      = scclk_pkg::TAG_W'(req.sector);
         off_in      = req.offset;
         len_in      = req.length;
         rd_idx_in   = '0;
         rd_done_in  = 1'b0;
         cmp_vld_in  = 1'b0;
         pend_vld_in = 1'b0;
      end

      // advance the read and compare stages
      if (scanning && !stall) begin
         cmp_vld_in = rd_en;
         if (rd_en) begin
            cmp_idx_in = rd_idx_ff;
            if (rd_idx_ff == LAST_IDX) begin
               rd_done_in = 1'b1;
            end else begin
               rd_idx_in = rd_idx_ff + 1'b1;
            end
         end
      end

      case (state_ff)
         scclk_pkg::S_LOOK: begin
            if (hit_now) begin
               ref_in[cmp_idx_ff] = 1'b1;
               if (op_ff == scclk_pkg::OP_WRITE) begin
                  dirty_in[cmp_idx_ff] = 1'b1;
               end
               pend_vld_in   = 1'b1;
               pend_hit_in   = 1'b1;
               pend_entry_in = cmp_idx_ff;
               pend_fill_in  = 1'b0;
               pend_wb_in    = 1'b0;
               pend_wbsec_in = '0;
               pend_off_in   = off_ff;
               pend_len_in   = len_ff;
            end
         end
         scclk_pkg::S_FLUSH: begin
            if (dirty_now && !stall) begin
               dirty_in[cmp_idx_ff] = 1'b0;
               pend_vld_in   = 1'b1;
               pend_hit_in   = 1'b0;
               pend_entry_in = cmp_idx_ff;
               pend_fill_in  = 1'b0;
               pend_wb_in    = 1'b1;
               pend_wbsec_in = tag_q;
               pend_off_in   = '0;
               pend_len_in   = '0;
            end
         end
         scclk_pkg::S_SWEEP: begin
            hand_in = hand_next;
            if (valid_ff[hand_ff] && ref_ff[hand_ff]) begin
               ref_in[hand_ff] = 1'b0;
            end else begin
               victim_in = hand_ff;
            end
         end
         scclk_pkg::S_FILL: begin
            pend_vld_in   = 1'b1;
            pend_hit_in   = 1'b0;
            pend_entry_in = victim_ff;
            pend_fill_in  = 1'b1;
            pend_wb_in    = valid_ff[victim_ff] && dirty_ff[victim_ff];
            pend_wbsec_in = (valid_ff[victim_ff] && dirty_ff[victim_ff]) ? tag_q : '0;
            pend_off_in   = off_ff;
            pend_len_in   = len_ff;
            valid_in[victim_ff] = 1'b1;
            ref_in[victim_ff]   = 1'b1;
            dirty_in[victim_ff] = (op_ff == scclk_pkg::OP_WRITE);
         end
         scclk_pkg::S_EMIT: begin
            if (out_free) begin
               pend_vld_in = 1'b0;
            end
         end
         default: hand_in = hand_ff;
      endcase
   end

   always_comb begin
      push.valid     = do_push;
      push.hit       = pend_hit_ff;
      push.entry     = scclk_pkg::ENTRY_W'(pend_entry_ff);
      push.fill      = pend_fill_ff;
      push.wb        = pend_wb_ff;
      push.wb_sector = scclk_pkg::SECTOR_W'(pend_wbsec_ff);
      push.addr      = (scclk_pkg::ADDR_W'(pend_entry_ff) << scclk_pkg::SEC_SHIFT)
                       + scclk_pkg::ADDR_W'(pend_off_ff);
      push.len       = pend_len_ff;
      push.last      = (state_ff == scclk_pkg::S_EMIT);
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff    <= scclk_pkg::S_IDLE;
         rd_done_ff  <= 1'b0;
         cmp_vld_ff  <= 1'b0;
         pend_vld_ff <= 1'b0;
         valid_ff    <= '0;
         dirty_ff    <= '0;
         ref_ff      <= '0;
         hand_ff     <= '0;
      end else begin
         state_ff    <= state_in;
         rd_done_ff  <= rd_done_in;
         cmp_vld_ff  <= cmp_vld_in;
         pend_vld_ff <= pend_vld_in;
         valid_ff    <= valid_in;
         dirty_ff    <= dirty_in;
         ref_ff      <= ref_in;
         hand_ff     <= hand_in;
      end
      op_ff         <= op_in;
      sec_ff        <= sec_in;
      off_ff        <= off_in;
      len_ff        <= len_in;
      rd_idx_ff     <= rd_idx_in;
      cmp_idx_ff    <= cmp_idx_in;
      victim_ff     <= victim_in;
      pend_hit_ff   <= pend_hit_in;
      pend_entry_ff <= pend_entry_in;
      pend_fill_ff  <= pend_fill_in;
      pend_wb_ff    <= pend_wb_in;
      pend_wbsec_ff <= pend_wbsec_in;
      pend_off_ff   <= pend_off_in;
      pend_len_ff   <= pend_len_in;
   end

endmodule

>>> hw/rtl/sector_cache_clock_replacement.sv
// Sequence: a hit on entry k ends the tag scan there and its item is pushed from
// the emit state; a miss scans all 64 tags, sweeps one entry a cycle and then
// passes the victim, fill and emit states. A flush scans 64 tags plus output stalls.
// Throughput: one request at a time, set by the sequencer, which is ready only when idle.
// Reset: synchronous; clears valid, dirty and reference bits and the clock hand.
// Tags hold no value until their entry is filled.
// ----------------------------------------------------------------------------
// Sector cache clock replacement
// Tag and clock replacement engine of a fully associative sector cache with a
// registered response stage.
// ----------------------------------------------------------------------------
module sector_cache_clock_replacement (
   input  logic       clock,
   input  logic       reset,
   scclk_req_if.sink  req,
   scclk_rsp_if.source rsp
);

   scclk_pkg::push_type push;
   logic                out_free;

   logic                          rsp_valid_ff, rsp_valid_in;
   logic                          rsp_hit_ff;
   logic [scclk_pkg::ENTRY_W-1:0]  rsp_entry_ff;
   logic                          rsp_fill_ff;
   logic                          rsp_wb_ff;
   logic [scclk_pkg::SECTOR_W-1:0] rsp_wbsec_ff;
   logic [scclk_pkg::ADDR_W-1:0]   rsp_addr_ff;
   logic [scclk_pkg::LENGTH_W-1:0] rsp_len_ff;
   logic                          rsp_last_ff;

   scclk_engine u_engine (
      .clock    (clock),
      .reset    (reset),
      .req      (req),
      .out_free (out_free),
      .push     (push)
   );

   assign out_free = !rsp_valid_ff || rsp.ready;

   always_comb begin
      rsp_valid_in = rsp_valid_ff;
      if (push.valid) begin
         rsp_valid_in = 1'b1;
      end else if (rsp.ready) begin
         rsp_valid_in = 1'b0;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
      if (push.valid) begin
         rsp_hit_ff   <= push.hit;
         rsp_entry_ff <= push.entry;
         rsp_fill_ff  <= push.fill;
         rsp_wb_ff    <= push.wb;
         rsp_wbsec_ff <= push.wb_sector;
         rsp_addr_ff  <= push.addr;
         rsp_len_ff   <= push.len;
         rsp_last_ff  <= push.last;
      end
   end

   assign rsp.valid            = rsp_valid_ff;
   assign rsp.hit              = rsp_hit_ff;
   assign rsp.entry            = rsp_entry_ff;
   assign rsp.fill_needed      = rsp_fill_ff;
   assign rsp.writeback_needed = rsp_wb_ff;
   assign rsp.writeback_sector = rsp_wbsec_ff;
   assign rsp.data_address     = rsp_addr_ff;
   assign rsp.copy_length      = rsp_len_ff;
   assign rsp.last             = rsp_last_ff;

endmodule
